>>> rtl/tcw_pkg.sv
// Shared constants, types and helper functions of the text console writer.
`default_nettype none

package tcw_pkg;

  // Screen geometry.
  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 25;
  localparam int TAB_STOP       = 8;
  localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;

  // Widths that follow from the geometry.
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int SUM_W  = ADDR_W + 1;
  localparam int COL_W  = $clog2(SCREEN_COLUMNS);
  localparam int NCOL_W = $clog2(SCREEN_COLUMNS + TAB_STOP);
  localparam int ROW_W  = (SCREEN_ROWS > 2) ? $clog2(SCREEN_ROWS) : 1;

  // Fixed field widths.
  localparam int KIND_W = 2;
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 11;
  localparam int LOC_W  = 11;
  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;
  localparam int CMP_W  = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_TEXT_ATTRIBUTE = '0;
  localparam logic [ATTR_W-1:0]  ATTR_RESET         = 8'h0F;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  // Character codes.
  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_DEL   = 8'h7F;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_CLEAR,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic             load;
    logic [LOC_W-1:0] loc;
    logic [CELL_W-1:0] cell_word;
  } result_t;

  typedef logic [NCOL_W-1:0] tab_next_t [SCREEN_COLUMNS];

  // Column that a tab reaches from each column, built without division.
  function automatic tab_next_t build_tab_next();
    int        stop;
    tab_next_t t;
    stop = TAB_STOP;
    for (int i = 0; i < SCREEN_COLUMNS; i++) begin
      if (i == stop) begin
        stop = stop + TAB_STOP;
      end
      t[i] = NCOL_W'(stop);
    end
    return t;
  endfunction

  localparam tab_next_t TAB_NEXT = build_tab_next();

  // Linear screen location of a cursor position.
  function automatic logic [ADDR_W-1:0] lin_loc(input logic [ROW_W-1:0] r,
                                                input logic [COL_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(c);
  endfunction

  // Memory address of a linear location, given the address of the top row.
  function automatic logic [ADDR_W-1:0] phys_addr(input logic [ADDR_W-1:0] loc,
                                                  input logic [ADDR_W-1:0] base);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(loc) + SUM_W'(base);
    if (sum >= SUM_W'(CELL_COUNT)) begin
      sum = sum - SUM_W'(CELL_COUNT);
    end
    return sum[ADDR_W-1:0];
  endfunction

  // Top row address after the screen moves up by one line.
  function automatic logic [ADDR_W-1:0] next_base(input logic [ADDR_W-1:0] base);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(SCREEN_COLUMNS);
    if (sum >= SUM_W'(CELL_COUNT)) begin
      sum = '0;
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/tcw_apb_regs.sv
// Configuration register file behind the APB port.
`default_nettype none

module tcw_apb_regs import tcw_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [ATTR_W-1:0]  text_attribute
);

  logic attr_sel;
  logic wr_xfer;

  assign attr_sel = (paddr[PADDR_W-1:2] == REG_TEXT_ATTRIBUTE);
  assign wr_xfer  = psel && penable && pwrite;
  assign pready   = 1'b1;
  assign prdata   = attr_sel ? PDATA_W'(text_attribute) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= ATTR_RESET;
    end else if (wr_xfer && attr_sel) begin
      text_attribute <= pwdata[ATTR_W-1:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/tcw_engine.sv
// Sequencer for cursor handling, screen memory access, scrolling and clearing.
`default_nettype none

module tcw_engine import tcw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [KIND_W-1:0] kind,
  input  logic [CHAR_W-1:0] char_code,
  input  logic [IDX_W-1:0]  cell_index,
  input  logic [ATTR_W-1:0] text_attribute,
  input  logic              out_free,
  output result_t           res,
  output mem_req_t          mem,
  input  logic [CELL_W-1:0] rdata
);

  state_t            state, state_next;
  logic [COL_W-1:0]  col, col_next;
  logic [ROW_W-1:0]  row, row_next;
  logic [ADDR_W-1:0] top_base, top_base_next;
  logic [ADDR_W-1:0] scroll_base, scroll_base_next;
  logic [ADDR_W-1:0] sweep, sweep_next;
  logic [KIND_W-1:0] it_kind, it_kind_next;
  logic [CHAR_W-1:0] it_code, it_code_next;
  logic              it_in_range, it_in_range_next;
  logic [CELL_W-1:0] hold_cell, hold_cell_next;

  logic              accept;
  logic              rd_in_range;
  logic              put_we;
  logic              need_scroll;
  logic              fin;
  logic              sweep_done;
  logic [CELL_W-1:0] fin_cell;
  logic [NCOL_W-1:0] col_step;
  logic              row_step;

  assign accept      = in_valid && (state == ST_IDLE);
  assign rd_in_range = (CMP_W'(cell_index) < CMP_W'(CELL_COUNT));
  assign sweep_done  = (sweep == ADDR_W'(CELL_COUNT - 1));

  // Cursor update and sweep bookkeeping.
  always_comb begin
    col_next         = col;
    row_next         = row;
    top_base_next    = top_base;
    scroll_base_next = scroll_base;
    sweep_next       = sweep;
    it_kind_next     = it_kind;
    it_code_next     = it_code;
    it_in_range_next = it_in_range;
    hold_cell_next   = hold_cell;
    put_we           = 1'b0;
    need_scroll      = 1'b0;
    fin              = 1'b0;
    fin_cell         = '0;
    col_step         = NCOL_W'(col);
    row_step         = 1'b0;

    case (state)
      ST_INIT: begin
        sweep_next = sweep + 1'b1;
      end
      ST_IDLE: begin
        if (accept) begin
          it_kind_next     = kind;
          it_code_next     = char_code;
          it_in_range_next = rd_in_range;
          if (kind == KIND_CLEAR) begin
            col_next      = '0;
            row_next      = '0;
            top_base_next = '0;
            sweep_next    = '0;
          end
        end
      end
      ST_EXEC: begin
        case (it_kind)
          KIND_PUT: begin
            case (it_code)
              CHAR_BS: begin
                if (col != '0) begin
                  col_step = NCOL_W'(col) - 1'b1;
                end
              end
              CHAR_TAB: col_step = TAB_NEXT[col];
              CHAR_CR:  col_step = '0;
              CHAR_LF: begin
                col_step = '0;
                row_step = 1'b1;
              end
              default: begin
                if (it_code inside {[CHAR_SPACE:CHAR_DEL]}) begin
                  put_we   = 1'b1;
                  col_step = NCOL_W'(col) + 1'b1;
                end
              end
            endcase
            if (col_step >= NCOL_W'(SCREEN_COLUMNS)) begin
              col_step = '0;
              row_step = 1'b1;
            end
            col_next = COL_W'(col_step);
            if (row_step) begin
              if (row == ROW_W'(SCREEN_ROWS - 1)) begin
                // The old top row becomes the new bottom row.
                need_scroll      = 1'b1;
                scroll_base_next = top_base;
                top_base_next    = next_base(top_base);
                sweep_next       = '0;
              end else begin
                row_next = row + 1'b1;
              end
            end
            fin = !need_scroll;
          end
          KIND_READ: begin
            fin      = 1'b1;
            fin_cell = it_in_range ? rdata : '0;
          end
          default: fin = 1'b1;
        endcase
      end
      ST_SCROLL: begin
        sweep_next = sweep + 1'b1;
        fin        = (sweep == ADDR_W'(SCREEN_COLUMNS - 1));
      end
      ST_CLEAR: begin
        sweep_next = sweep + 1'b1;
        fin        = sweep_done;
      end
      ST_HOLD: begin
        fin      = 1'b1;
        fin_cell = hold_cell;
      end
      default: ;
    endcase

    if (fin && !out_free) begin
      hold_cell_next = fin_cell;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (sweep_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = (kind == KIND_CLEAR) ? ST_CLEAR : ST_EXEC;
        end
      end
      ST_EXEC, ST_SCROLL, ST_CLEAR, ST_HOLD: begin
        if (need_scroll) begin
          state_next = ST_SCROLL;
        end else if (fin) begin
          state_next = out_free ? ST_IDLE : ST_HOLD;
        end
      end
      default: state_next = ST_INIT;
    endcase
  end

  // Memory requests and result hand-off. Reads are issued only in idle and
  // writes only outside it, so the two ports never touch one entry together.
  always_comb begin
    mem      = '0;
    in_stall = (state != ST_IDLE);
    case (state)
      ST_INIT: begin
        mem.we    = 1'b1;
        mem.waddr = sweep;
        mem.wdata = {ATTR_RESET, CHAR_SPACE};
      end
      ST_IDLE: begin
        mem.re    = accept && rd_in_range && (kind == KIND_READ);
        mem.raddr = phys_addr(ADDR_W'(cell_index), top_base);
      end
      ST_EXEC: begin
        mem.we    = put_we;
        mem.waddr = phys_addr(lin_loc(row, col), top_base);
        mem.wdata = {text_attribute, it_code};
      end
      ST_SCROLL: begin
        mem.we    = 1'b1;
        mem.waddr = scroll_base + sweep;
        mem.wdata = {text_attribute, CHAR_SPACE};
      end
      ST_CLEAR: begin
        mem.we    = 1'b1;
        mem.waddr = sweep;
        mem.wdata = {text_attribute, CHAR_SPACE};
      end
      default: ;
    endcase
    res.load      = fin && out_free;
    res.loc       = LOC_W'(lin_loc(row_next, col_next));
    res.cell_word = fin_cell;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_INIT;
      col      <= '0;
      row      <= '0;
      top_base <= '0;
      sweep    <= '0;
    end else begin
      state    <= state_next;
      col      <= col_next;
      row      <= row_next;
      top_base <= top_base_next;
      sweep    <= sweep_next;
    end
  end

  always_ff @(posedge clk) begin
    scroll_base <= scroll_base_next;
    it_kind     <= it_kind_next;
    it_code     <= it_code_next;
    it_in_range <= it_in_range_next;
    hold_cell   <= hold_cell_next;
  end

endmodule

`default_nettype wire

>>> rtl/text_console_writer.sv
// Top level of the text console writer: config port, engine, screen memory, result register.
// A put, read or unused item is taken in the idle state, then worked in the execute state.
// A put that scrolls then blanks the SCREEN_COLUMNS cells (80) of the new bottom row in memory.
// A clear item blanks all SCREEN_COLUMNS*SCREEN_ROWS cells (2000), one memory write a cycle.
// The result appears in the output register the cycle after the last engine cycle.
// After reset, a sweep blanks all 2000 memory cells with attribute 0x0F while in_stall is high.
`default_nettype none

module text_console_writer import tcw_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // Input items.
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [KIND_W-1:0]  kind,
  input  logic [CHAR_W-1:0]  char_code,
  input  logic [IDX_W-1:0]   cell_index,
  // Results.
  output logic               out_valid,
  input  logic               out_stall,
  output logic [LOC_W-1:0]   cursor_location,
  output logic [CELL_W-1:0]  cell_value,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [ATTR_W-1:0] text_attribute;
  logic              out_free;
  result_t           res;
  mem_req_t          mem;
  logic [CELL_W-1:0] rdata;

  // The user must write the attribute register only while the engine is idle, so it needs
  // no shadow copy; the block itself does not enforce this.
  tcw_apb_regs u_regs (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .text_attribute (text_attribute)
  );

  // The engine holds the cursor and the top-row offset. Scrolling moves the
  // offset instead of copying rows, so only the new bottom row is rewritten.
  tcw_engine u_engine (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .kind           (kind),
    .char_code      (char_code),
    .cell_index     (cell_index),
    .text_attribute (text_attribute),
    .out_free       (out_free),
    .res            (res),
    .mem            (mem),
    .rdata          (rdata)
  );

  // Screen store: one cell per word, attribute in the high byte.
  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_screen (
    .clk   (clk),
    .we    (mem.we),
    .waddr (mem.waddr),
    .wdata (mem.wdata),
    .re    (mem.re),
    .raddr (mem.raddr),
    .rdata (rdata)
  );

  // The output register frees the engine from the consumer: the engine can
  // take the next item while this result waits for its transfer. It may be
  // reloaded in the same cycle that its current result is transferred.
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      cursor_location <= res.loc;
      cell_value      <= res.cell_word;
    end
  end

endmodule

`default_nettype wire

>>> rtl/tcw_checker.sv
// Port-level checks of the text console writer and their binding to the top level.
`default_nettype none

module tcw_checker (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_stall,
  input wire        out_valid,
  input wire        out_stall,
  input wire [10:0] cursor_location,
  input wire [15:0] cell_value
);

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(cursor_location) && $stable(cell_value))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_rst_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

  // Items are worked one at a time: a transfer in closes the input.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after a transfer");

  // A new result only comes from an item that was being worked on.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared with no item in work");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .cursor_location (cursor_location),
  .cell_value      (cell_value)
);

`default_nettype wire
